// File: src/ifla_pkg.sv
// Package for the implicit free list allocator: sizes, operation and status
// codes, and the sequencer state type. No dependencies.
package ifla_pkg;

   localparam int HEAP_SIZE = 128;
   localparam int ADDR_W    = $clog2(HEAP_SIZE);
   localparam int PTR_W     = ADDR_W + 1;
   localparam int ARENA_END = HEAP_SIZE - 2;

   localparam int FUNC_W   = 2;
   localparam int AMOUNT_W = 7;
   localparam int ID_W     = 8;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int SIZE_W   = BYTE_W - 1;

   // Header byte of the single free block that covers the arena after reset
   localparam logic [BYTE_W-1:0] HDR_INIT = BYTE_W'((ARENA_END & 127) << 1);
   localparam logic [PTR_W-1:0]  ARENA_END_P = PTR_W'(ARENA_END);
   localparam logic [PTR_W-1:0]  HEAP_SIZE_P = PTR_W'(HEAP_SIZE);

   typedef enum logic [FUNC_W-1:0] {
      FN_ALLOC = 2'd0,
      FN_FREE  = 2'd1,
      FN_WRITE = 2'd2,
      FN_READ  = 2'd3
   } ifla_func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_INVALID   = 3'd1,
      ST_NOT_FOUND = 3'd2,
      ST_NO_SPACE  = 3'd3,
      ST_TOO_BIG   = 3'd4,
      ST_UNALLOC   = 3'd5
   } ifla_status_type;

   typedef enum logic [3:0] {
      S_INIT0,
      S_INIT1,
      S_IDLE,
      S_WALK_ID,
      S_WALK_SZ,
      S_WALK_CHK,
      S_ALLOC_HDR,
      S_ALLOC_RID,
      S_ALLOC_RSZ,
      S_FILL,
      S_FINISH
   } ifla_state_type;

endpackage

// File: src/ifla_if.sv
// Valid/ready channel interfaces for the allocator's request and response items.
// Depends on ifla_pkg for field widths.
interface ifla_req_if;
   logic                              valid;
   logic                              ready;
   logic [ifla_pkg::FUNC_W-1:0]       func;
   logic [ifla_pkg::AMOUNT_W-1:0]     amount;
   logic [ifla_pkg::ID_W-1:0]         block_id;
   logic [ifla_pkg::BYTE_W-1:0]       fill_byte;

   modport source (output valid, func, amount, block_id, fill_byte, input ready);
   modport sink   (input valid, func, amount, block_id, fill_byte, output ready);
endinterface

interface ifla_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [ifla_pkg::STATUS_W-1:0]     status;
   logic [ifla_pkg::ID_W-1:0]         assigned_id;
   logic [ifla_pkg::BYTE_W-1:0]       header_first;
   logic [ifla_pkg::BYTE_W-1:0]       header_second;

   modport source (output valid, status, assigned_id, header_first, header_second,
                   input ready);
   modport sink   (input valid, status, assigned_id, header_first, header_second,
                   output ready);
endinterface

// File: src/ifla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ifla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/implicit_free_list_allocator.sv
// Implicit free list allocator (first fit) over a 128-byte heap RAM.
// Depends on ifla_pkg, ifla_if (ifla_req_if, ifla_rsp_if) and ifla_ram.
//
// Usage:
//   req_chan carries one operation item: func (allocate, free, write payload,
//   read header), amount, block_id and fill_byte. rsp_chan returns exactly one
//   item per request: status, assigned_id and the two header bytes.
//   The block takes one request at a time. A small sequencer walks the block
//   headers through a single RAM read port, reading each header's id byte and
//   then its size byte (S_WALK_ID, S_WALK_SZ, S_WALK_CHK). A walk stops on a
//   match, a broken size or the end of the arena. An allocation writes the new
//   id, then the size (S_ALLOC_HDR) and, when it splits off a free tail, the
//   tail's header (S_ALLOC_RID, S_ALLOC_RSZ); a write stores its payload bytes
//   in S_FILL. An invalid block number skips the walk. The block is ready for
//   the next request in the same cycle that the response turns valid.
//   The response sits in an output register: the block returns to idle and
//   takes the next request while that response waits, and stalls at the
//   end of the next operation until the receiver takes the old one.
//   Reset (synchronous, active high) clears the counter and the response
//   valid, then writes the initial free header at the start of the heap in
//   states S_INIT0 and S_INIT1; req_chan.ready stays low in those states.
module implicit_free_list_allocator (
   input  logic         clock,
   input  logic         reset,
   ifla_req_if.sink     req_chan,
   ifla_rsp_if.source   rsp_chan
);

   ifla_pkg::ifla_state_type state_ff, state_in;

   logic [ifla_pkg::PTR_W-1:0]    pos_ff, pos_in;
   logic [ifla_pkg::PTR_W-1:0]    ptr_ff, ptr_in;
   logic [ifla_pkg::AMOUNT_W-1:0] cnt_ff, cnt_in;
   logic [ifla_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [ifla_pkg::AMOUNT_W-1:0] amount_ff, amount_in;
   logic [ifla_pkg::ID_W-1:0]     id_ff, id_in;
   logic [ifla_pkg::BYTE_W-1:0]   fill_ff, fill_in;
   logic [ifla_pkg::ID_W-1:0]     count_ff, count_in;
   logic [ifla_pkg::BYTE_W-1:0]   hid_ff, hid_in;
   logic [ifla_pkg::BYTE_W-1:0]   hb_ff, hb_in;

   logic [ifla_pkg::STATUS_W-1:0] st_ff, st_in;
   logic [ifla_pkg::ID_W-1:0]     aid_ff, aid_in;
   logic [ifla_pkg::BYTE_W-1:0]   h1_ff, h1_in;
   logic [ifla_pkg::BYTE_W-1:0]   h2_ff, h2_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [ifla_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ifla_pkg::ID_W-1:0]     rsp_aid_ff, rsp_aid_in;
   logic [ifla_pkg::BYTE_W-1:0]   rsp_h1_ff, rsp_h1_in;
   logic [ifla_pkg::BYTE_W-1:0]   rsp_h2_ff, rsp_h2_in;

   logic                          ram_we;
   logic [ifla_pkg::PTR_W-1:0]    ram_waddr;
   logic [ifla_pkg::BYTE_W-1:0]   ram_wdata;
   logic [ifla_pkg::PTR_W-1:0]    ram_raddr;
   logic [ifla_pkg::BYTE_W-1:0]   ram_rdata;

   // Shared arithmetic on the header under inspection
   logic [ifla_pkg::PTR_W-1:0]    need;
   logic [ifla_pkg::PTR_W-1:0]    cur_sz;
   logic [ifla_pkg::PTR_W-1:0]    old_sz;
   logic [ifla_pkg::PTR_W-1:0]    left;
   logic [ifla_pkg::SIZE_W-1:0]   taken;
   logic [ifla_pkg::ID_W-1:0]     next_id;

   ifla_ram #(
      .WIDTH (ifla_pkg::BYTE_W),
      .DEPTH (ifla_pkg::HEAP_SIZE)
   ) u_heap (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr[ifla_pkg::ADDR_W-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr[ifla_pkg::ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign need    = ifla_pkg::PTR_W'(amount_ff) + ifla_pkg::PTR_W'(2);
   assign cur_sz  = ifla_pkg::PTR_W'(ram_rdata[ifla_pkg::BYTE_W-1:1]);
   assign old_sz  = ifla_pkg::PTR_W'(hb_ff[ifla_pkg::BYTE_W-1:1]);
   assign left    = old_sz - need;
   assign taken   = (left < ifla_pkg::PTR_W'(2)) ? hb_ff[ifla_pkg::BYTE_W-1:1]
                                                  : need[ifla_pkg::SIZE_W-1:0];
   assign next_id = count_ff + ifla_pkg::ID_W'(1);

   // Sequencer: next state, datapath updates and RAM control
   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      ptr_in        = ptr_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      amount_in     = amount_ff;
      id_in         = id_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      hid_in        = hid_ff;
      hb_in         = hb_ff;
      st_in         = st_ff;
      aid_in        = aid_ff;
      h1_in         = h1_ff;
      h2_in         = h2_ff;
      rsp_status_in = rsp_status_ff;
      rsp_aid_in    = rsp_aid_ff;
      rsp_h1_in     = rsp_h1_ff;
      rsp_h2_in     = rsp_h2_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      ram_we        = 1'b0;
      ram_waddr     = pos_ff;
      ram_wdata     = '0;
      ram_raddr     = pos_ff;
      req_chan.ready = 1'b0;

      case (state_ff)
         ifla_pkg::S_INIT0: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            state_in  = ifla_pkg::S_INIT1;
         end
         ifla_pkg::S_INIT1: begin
            ram_we    = 1'b1;
            ram_waddr = ifla_pkg::PTR_W'(1);
            ram_wdata = ifla_pkg::HDR_INIT;
            state_in  = ifla_pkg::S_IDLE;
         end
         ifla_pkg::S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               func_in   = req_chan.func;
               amount_in = req_chan.amount;
               id_in     = req_chan.block_id;
               fill_in   = req_chan.fill_byte;
               pos_in    = '0;
               st_in     = ifla_pkg::ST_OK;
               aid_in    = '0;
               h1_in     = '0;
               h2_in     = '0;
               if (req_chan.func != ifla_pkg::FN_ALLOC &&
                   req_chan.block_id > count_ff) begin
                  st_in    = ifla_pkg::ST_INVALID;
                  state_in = ifla_pkg::S_FINISH;
               end else begin
                  state_in = ifla_pkg::S_WALK_ID;
               end
            end
         end
         ifla_pkg::S_WALK_ID: begin
            // End of arena closes the walk
            if (pos_ff >= ifla_pkg::ARENA_END_P) begin
               st_in    = (func_ff == ifla_pkg::FN_ALLOC) ? ifla_pkg::ST_NO_SPACE
                                                          : ifla_pkg::ST_NOT_FOUND;
               state_in = ifla_pkg::S_FINISH;
            end else begin
               ram_raddr = pos_ff;
               state_in  = ifla_pkg::S_WALK_SZ;
            end
         end
         ifla_pkg::S_WALK_SZ: begin
            ram_raddr = pos_ff + ifla_pkg::PTR_W'(1);
            hid_in    = ram_rdata;
            state_in  = ifla_pkg::S_WALK_CHK;
         end
         ifla_pkg::S_WALK_CHK: begin
            hb_in = ram_rdata;
            if (func_ff == ifla_pkg::FN_ALLOC) begin
               if (cur_sz < ifla_pkg::PTR_W'(2)) begin
                  st_in    = ifla_pkg::ST_NO_SPACE;
                  state_in = ifla_pkg::S_FINISH;
               end else if (!ram_rdata[0] && cur_sz >= need) begin
                  // Take this block: number it now, size it next
                  count_in  = next_id;
                  aid_in    = next_id;
                  ram_we    = 1'b1;
                  ram_waddr = pos_ff;
                  ram_wdata = next_id;
                  state_in  = ifla_pkg::S_ALLOC_HDR;
               end else begin
                  pos_in   = pos_ff + cur_sz;
                  state_in = ifla_pkg::S_WALK_ID;
               end
            end else if (hid_ff == id_ff) begin
               state_in = ifla_pkg::S_FINISH;
               case (func_ff)
                  ifla_pkg::FN_FREE: begin
                     ram_we    = 1'b1;
                     ram_waddr = pos_ff + ifla_pkg::PTR_W'(1);
                     ram_wdata = {ram_rdata[ifla_pkg::BYTE_W-1:1], 1'b0};
                  end
                  ifla_pkg::FN_READ: begin
                     h1_in = hid_ff;
                     h2_in = ram_rdata;
                  end
                  ifla_pkg::FN_WRITE: begin
                     if (cur_sz < need) begin
                        st_in = ifla_pkg::ST_TOO_BIG;
                     end else if (!ram_rdata[0]) begin
                        st_in = ifla_pkg::ST_UNALLOC;
                     end else begin
                        ptr_in   = pos_ff + ifla_pkg::PTR_W'(2);
                        cnt_in   = amount_ff;
                        state_in = ifla_pkg::S_FILL;
                     end
                  end
                  default: begin
                     st_in = ifla_pkg::ST_OK;
                  end
               endcase
            end else if (cur_sz < ifla_pkg::PTR_W'(2)) begin
               st_in    = ifla_pkg::ST_NOT_FOUND;
               state_in = ifla_pkg::S_FINISH;
            end else begin
               pos_in   = pos_ff + cur_sz;
               state_in = ifla_pkg::S_WALK_ID;
            end
         end
         ifla_pkg::S_ALLOC_HDR: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff + ifla_pkg::PTR_W'(1);
            ram_wdata = {taken, 1'b1};
            state_in  = (left >= ifla_pkg::PTR_W'(2)) ? ifla_pkg::S_ALLOC_RID
                                                      : ifla_pkg::S_FINISH;
         end
         ifla_pkg::S_ALLOC_RID: begin
            // Remainder keeps the old block number
            ram_we    = 1'b1;
            ram_waddr = pos_ff + need;
            ram_wdata = hid_ff;
            state_in  = ifla_pkg::S_ALLOC_RSZ;
         end
         ifla_pkg::S_ALLOC_RSZ: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff + need + ifla_pkg::PTR_W'(1);
            ram_wdata = {left[ifla_pkg::SIZE_W-1:0], 1'b0};
            state_in  = ifla_pkg::S_FINISH;
         end
         ifla_pkg::S_FILL: begin
            // Store one payload byte a cycle
            if (cnt_ff == '0) begin
               state_in = ifla_pkg::S_FINISH;
            end else begin
               ram_we    = (ptr_ff < ifla_pkg::HEAP_SIZE_P);
               ram_waddr = ptr_ff;
               ram_wdata = fill_ff;
               ptr_in    = ptr_ff + ifla_pkg::PTR_W'(1);
               cnt_in    = cnt_ff - ifla_pkg::AMOUNT_W'(1);
            end
         end
         ifla_pkg::S_FINISH: begin
            // Hand the result to the output register once it is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_aid_in    = aid_ff;
               rsp_h1_in     = h1_ff;
               rsp_h2_in     = h2_ff;
               state_in      = ifla_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ifla_pkg::S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ifla_pkg::S_INIT0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      ptr_ff        <= ptr_in;
      cnt_ff        <= cnt_in;
      func_ff       <= func_in;
      amount_ff     <= amount_in;
      id_ff         <= id_in;
      fill_ff       <= fill_in;
      hid_ff        <= hid_in;
      hb_ff         <= hb_in;
      st_ff         <= st_in;
      aid_ff        <= aid_in;
      h1_ff         <= h1_in;
      h2_ff         <= h2_in;
      rsp_status_ff <= rsp_status_in;
      rsp_aid_ff    <= rsp_aid_in;
      rsp_h1_ff     <= rsp_h1_in;
      rsp_h2_ff     <= rsp_h2_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.assigned_id   = rsp_aid_ff;
   assign rsp_chan.header_first  = rsp_h1_ff;
   assign rsp_chan.header_second = rsp_h2_ff;

endmodule
